// ===== rtl/core/button_event_queue_registers_assert.svh =====
// assertion macros for the button event queue
`ifndef BUTTON_EVENT_QUEUE_REGISTERS_ASSERT_SVH
`define BUTTON_EVENT_QUEUE_REGISTERS_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define BEQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define BEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BEQ_ASSERT_ALWAYS(label, cond, msg)
`define BEQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/beq_pkg.sv =====
`default_nettype none

package beq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_BUTTONS     = 4;

    localparam logic       CMD_SAMPLE   = 1'b0;
    localparam logic       CMD_READ     = 1'b1;
    localparam logic [3:0] ADDR_COUNT   = 4'd0;
    localparam logic [3:0] ADDR_POP     = 4'd1;
    localparam logic [7:0] CODE_PRESS   = 8'h80;
    localparam logic [7:0] CODE_RELEASE = 8'h40;

    typedef struct packed {
        logic                   command;
        logic [NUM_BUTTONS-1:0] button_levels;
        logic [3:0]             reg_address;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       led_on;
    } out_item_t;

    // one queue write request from the event sequencer
    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } push_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/beq_stream_if.sv =====
`default_nettype none

interface beq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/beq_events.sv =====
`default_nettype none

module beq_events (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            sample_fire,
    input  wire logic [beq_pkg::NUM_BUTTONS-1:0] levels,
    output beq_pkg::push_req_t                   push,
    output logic                                 busy,
    output logic                                 led_reg,
    output logic                                 led_next
);

    logic [beq_pkg::NUM_BUTTONS-1:0]   prev_reg;
    logic [beq_pkg::NUM_BUTTONS-1:0]   pressed;
    logic [beq_pkg::NUM_BUTTONS-1:0]   released;
    // presses in the low half, releases in the high half
    logic [2*beq_pkg::NUM_BUTTONS-1:0] pend_reg;
    logic [2:0]                        idx;

    assign pressed  = prev_reg & ~levels;
    assign released = levels & ~prev_reg;
    assign busy     = (pend_reg != '0);

    always_comb
    begin
        if (released != '0)
            led_next = 1'b0;
        else if (pressed != '0)
            led_next = 1'b1;
        else
            led_next = led_reg;
    end

    // lowest pending event goes first
    always_comb
    begin
        idx = '0;
        for (int i = 2*beq_pkg::NUM_BUTTONS-1; i >= 0; i--)
        begin
            if (pend_reg[i])
                idx = 3'(i);
        end
    end

    always_comb
    begin
        push.valid = busy;
        push.code  = (idx[2] ? beq_pkg::CODE_RELEASE : beq_pkg::CODE_PRESS)
                   | 8'(3'(idx[1:0]) + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            led_reg  <= 1'b0;
            pend_reg <= '0;
        end
        else if (sample_fire)
        begin
            prev_reg <= levels;
            led_reg  <= led_next;
            pend_reg <= {released, pressed};
        end
        else if (busy)
        begin
            pend_reg <= pend_reg & (pend_reg - 1'b1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/beq_fifo.sv =====
`default_nettype none

module beq_fifo #(
    parameter int DEPTH = beq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire beq_pkg::push_req_t         push,
    input  wire logic                       pop,
    output logic [$clog2(DEPTH+1)-1:0]      count,
    output logic [7:0]                      head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_q;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          we;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    // pushes to a full queue are dropped
    assign we          = push.valid && (count_reg != CW'(DEPTH));
    assign rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
    assign count       = count_reg;
    assign head        = fwd_reg ? fwd_data_reg : mem_q;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_ptr_reg] <= push.code;
        mem_q        <= mem[rd_ptr_next];
        fwd_data_reg <= push.code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            // write into the slot being read this edge: take the new code
            fwd_reg    <= we && (wr_ptr_reg == rd_ptr_next);
            if (we)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (we && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !we)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/button_event_queue_registers.sv =====
// channel  | dir | beat payload
// ---------+-----+-------------------------------------------
// in_ch    | in  | command, button_levels, reg_address
// out_ch   | out | read_data, led_on
//
// beats pass through an item register and a result register; a new beat is taken as the last moves on
// a sample beat with button edges holds off the next beat until all its events are
// written: the event store has one write port, one event written per cycle
// reset clears pointers, count, levels, led and last popped value, not the event store
// a stalled result holds in the result register while the item register
// still takes one more beat
`default_nettype none

`include "button_event_queue_registers_assert.svh"

module button_event_queue_registers #(
    parameter int QUEUE_DEPTH = beq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    beq_stream_if.sink   in_ch,
    beq_stream_if.source out_ch
);

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    // item register
    logic                 item_valid_reg;
    beq_pkg::in_item_t    item_reg;

    // result register
    logic                 out_valid_reg;
    beq_pkg::out_item_t   out_reg;
    beq_pkg::out_item_t   out_next;

    logic [7:0]           last_popped_reg;
    logic                 fire;
    logic                 is_read;
    logic                 pop;
    logic                 sample_fire;

    beq_pkg::push_req_t   push;
    logic                 busy;
    logic                 led_reg;
    logic                 led_next;
    logic [CW-1:0]        count;
    logic [7:0]           head;

    // the item moves on once queued events are written and the result slot frees
    assign fire        = item_valid_reg && !busy && (!out_valid_reg || out_ch.ready);
    assign is_read     = (item_reg.command == beq_pkg::CMD_READ);
    assign sample_fire = fire && !is_read;
    // a pop on an empty queue changes nothing
    assign pop         = fire && is_read && (item_reg.reg_address == beq_pkg::ADDR_POP)
                       && (count != '0);

    assign in_ch.ready  = !item_valid_reg || fire;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    beq_events u_events (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_fire (sample_fire),
        .levels      (item_reg.button_levels),
        .push        (push),
        .busy        (busy),
        .led_reg     (led_reg),
        .led_next    (led_next)
    );

    beq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .count (count),
        .head  (head)
    );

    // register read decode and led level of each result
    always_comb
    begin
        out_next.led_on    = is_read ? led_reg : led_next;
        out_next.read_data = '0;
        if (is_read)
        begin
            unique case (item_reg.reg_address)
                beq_pkg::ADDR_COUNT: out_next.read_data = 8'(count);
                beq_pkg::ADDR_POP:   out_next.read_data = (count != '0) ? head
                                                                        : last_popped_reg;
                default:             out_next.read_data = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_popped_reg <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                item_valid_reg <= 1'b1;
            else if (fire)
                item_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (pop)
                last_popped_reg <= head;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            item_reg <= in_ch.data;
        if (fire)
            out_reg <= out_next;
    end

    // checks
    `BEQ_ASSERT_ALWAYS(a_count_bound, count <= CW'(QUEUE_DEPTH), "event count beyond depth")
    `BEQ_ASSERT_NEXT(a_pop_count, pop, count == $past(count) - 1'b1, "pop did not drop the count")
    `BEQ_ASSERT_NEXT(a_led_follow, sample_fire, led_reg == $past(led_next), "led did not follow")
    `BEQ_ASSERT_NEXT(a_hold, out_valid_reg && !out_ch.ready, $stable(out_reg), "stall broke")

endmodule

`default_nettype wire

// ===== tb/sv/button_event_queue_registers_tb.sv =====
`default_nettype none

module button_event_queue_registers_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int EVENT_SLOTS  = beq_pkg::QUEUE_DEPTH_DEF;
    localparam int BEATS_PHASE  = 510;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    // tracks the button edges and the event queue and holds the outputs still awaited
    class button_event_tracker;
        beq_pkg::out_item_t awaited_outputs[$];
        logic [7:0] queued_codes[$];
        logic [3:0] last_levels;
        logic [7:0] last_popped;
        logic       led_level;
        int         mismatches;
        int         samples;
        int         reads;
        int         codes_queued;
        int         codes_dropped;
        int         empty_pops;
        int         full_hits;

        function new();
            last_levels = '0;
            last_popped = '0;
            led_level   = 1'b0;
        endfunction

        function void queue_code(logic [7:0] code);
            if (queued_codes.size() >= EVENT_SLOTS)
            begin
                codes_dropped++;
                return;
            end
            queued_codes.push_back(code);
            codes_queued++;
            if (queued_codes.size() == EVENT_SLOTS)
                full_hits++;
        endfunction

        // predicts the output of one accepted input beat
        function void note_beat(beq_pkg::in_item_t beat);
            beq_pkg::out_item_t outcome;
            logic [3:0] pressed;
            logic [3:0] released;
            outcome.read_data = '0;
            if (beat.command == beq_pkg::CMD_SAMPLE)
            begin
                samples++;
                pressed  = last_levels & ~beat.button_levels;
                released = beat.button_levels & ~last_levels;
                for (int b = 0; b < beq_pkg::NUM_BUTTONS; b++)
                    if (pressed[b])
                        queue_code(beq_pkg::CODE_PRESS | 8'(b + 1));
                for (int b = 0; b < beq_pkg::NUM_BUTTONS; b++)
                    if (released[b])
                        queue_code(beq_pkg::CODE_RELEASE | 8'(b + 1));
                if (released != '0)
                    led_level = 1'b0;
                else if (pressed != '0)
                    led_level = 1'b1;
                last_levels = beat.button_levels;
            end
            else
            begin
                reads++;
                if (beat.reg_address == beq_pkg::ADDR_COUNT)
                    outcome.read_data = 8'(queued_codes.size());
                else if (beat.reg_address == beq_pkg::ADDR_POP)
                begin
                    if (queued_codes.size() == 0)
                        empty_pops++;
                    else
                        last_popped = queued_codes.pop_front();
                    outcome.read_data = last_popped;
                end
            end
            outcome.led_on = led_level;
            awaited_outputs.push_back(outcome);
        endfunction

        function void flag(string what, logic [7:0] want, logic [7:0] seen);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t ns: %s mismatch, expected %02h, got %02h", $realtime, what,
                         want, seen);
        endfunction

        function void check_beat(beq_pkg::out_item_t seen);
            beq_pkg::out_item_t want;
            if (awaited_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t ns: unexpected output beat, read_data %02h led_on %0b",
                             $realtime, seen.read_data, seen.led_on);
                return;
            end
            want = awaited_outputs.pop_front();
            if (seen.read_data !== want.read_data)
                flag("read_data", want.read_data, seen.read_data);
            if (seen.led_on !== want.led_on)
                flag("led_on", 8'(want.led_on), 8'(seen.led_on));
        endfunction

        function int outstanding();
            return awaited_outputs.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    beq_stream_if #(.payload_t(beq_pkg::in_item_t))  in_ch ();
    beq_stream_if #(.payload_t(beq_pkg::out_item_t)) out_ch ();

    button_event_queue_registers #(
        .QUEUE_DEPTH (EVENT_SLOTS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    button_event_tracker tracker = new();

    // idling rates and phase updated with nonblocking writes at the clock edge, cycle count directly
    int run_phase    = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int cycle_count  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still awaited", cycle_count,
                 tracker.outstanding());
        $display("RESULT: ERROR");
        $finish;
    end

    // receiving side: handshake sampled at the falling edge, checked at the rising edge,
    // then ready picked for the next edge
    initial
    begin
        int                 hold_left;
        bit                 hold_done;
        bit                 take;
        beq_pkg::out_item_t seen;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b1;
        forever
        begin
            @(negedge clk);
            take = rst_n && out_ch.valid && out_ch.ready;
            seen = out_ch.data;
            @(posedge clk);
            if (take)
                tracker.check_beat(seen);
            // one long hold-off in the last phase while the sender keeps offering beats,
            // so the item and result registers fill and the input stalls
            if (!hold_done && run_phase == 2)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // one beat offered, with random idle cycles in front, held until accepted
    task automatic send_beat(input beq_pkg::in_item_t beat);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= beat;
        // ready is settled by the falling edge and holds up to the next rising edge
        do
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        tracker.note_beat(beat);
    endtask

    // the field a command ignores still gets random bits
    task automatic sample_buttons(input logic [3:0] levels);
        beq_pkg::in_item_t beat;
        beat.command       = beq_pkg::CMD_SAMPLE;
        beat.button_levels = levels;
        beat.reg_address   = 4'($urandom_range(0, 15));
        send_beat(beat);
    endtask

    task automatic read_register(input logic [3:0] address);
        beq_pkg::in_item_t beat;
        beat.command       = beq_pkg::CMD_READ;
        beat.button_levels = 4'($urandom_range(0, 15));
        beat.reg_address   = address;
        send_beat(beat);
    endtask

    // mostly pops and count reads, a few stray addresses; the sample share drifts so the
    // queue swings between empty and full
    task automatic send_random_beat(input int sample_pct);
        int pick;
        if ($urandom_range(0, 99) < sample_pct)
            sample_buttons(4'($urandom_range(0, 15)));
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                read_register(beq_pkg::ADDR_POP);
            else if (pick < 90)
                read_register(beq_pkg::ADDR_COUNT);
            else
                read_register(4'($urandom_range(2, 15)));
        end
    endtask

    initial
    begin
        int sample_pct;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.data     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++)
        begin
            run_phase <= ph;
            case (ph)
                0:
                begin
                    tx_idle_pct  <= 21;
                    rx_stall_pct <= 69;
                end
                1:
                begin
                    tx_idle_pct  <= 69;
                    rx_stall_pct <= 21;
                end
                default:
                begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 0;
                end
            endcase

            if (ph == 0)
            begin
                // empty queue straight after reset: count 0, pop gives the cleared value
                read_register(beq_pkg::ADDR_COUNT);
                read_register(beq_pkg::ADDR_POP);
                // first sample: all previous levels low, so every high button is a release
                sample_buttons(4'hF);
                read_register(beq_pkg::ADDR_COUNT);
                repeat (4) read_register(beq_pkg::ADDR_POP);
                // pop on empty repeats the last popped code
                read_register(beq_pkg::ADDR_POP);
                // all pressed, then no edges at all: led holds
                sample_buttons(4'h0);
                sample_buttons(4'h0);
                // releases only, then presses and releases together: release wins
                sample_buttons(4'b1010);
                sample_buttons(4'b0101);
                sample_buttons(4'hF);
                // fill to the brim, then overflow: codes dropped but led still follows
                sample_buttons(4'h0);
                sample_buttons(4'hF);
                read_register(beq_pkg::ADDR_COUNT);
                read_register(4'd2);
                read_register(4'd15);
                sample_buttons(4'b1110);
                repeat (6) read_register(beq_pkg::ADDR_POP);
                read_register(beq_pkg::ADDR_COUNT);
            end

            sample_pct = 50;
            for (int n = 0; n < BEATS_PHASE; n++)
            begin
                if (n % 64 == 0)
                    case ($urandom_range(0, 2))
                        0:       sample_pct = 20;
                        1:       sample_pct = 50;
                        default: sample_pct = 80;
                    endcase
                send_random_beat(sample_pct);
            end
        end

        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        // a sample beat can still be writing codes after its output has gone
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d sample and %0d read beats; %0d codes queued, %0d dropped",
                 tracker.samples, tracker.reads, tracker.codes_queued, tracker.codes_dropped);
        $display("queue reached full %0d times, %0d pops on an empty queue, %0d mismatches",
                 tracker.full_hits, tracker.empty_pops, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
